// File: sv/vnh_pkg.sv
// Shared widths, register indexes and reset values for the value noise heightmap core.
`timescale 1ns / 1ps
package vnh_pkg;
    localparam int FREQ_W   = 16;
    localparam int COORD_W  = 16;
    localparam int OCT_W    = 20;   // octave value, signed Q3.16
    localparam int OCT_STG  = 7;    // register stages inside one octave lane
    localparam int HEIGHT_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_HEIGHT  = 3'd0,
        REG_HEIGHT_RANGE = 3'd1,
        REG_FIRST_FREQ   = 3'd2,
        REG_SECOND_FREQ  = 3'd3,
        REG_FIRST_WEIGHT = 3'd4,
        REG_SECOND_WEIGHT = 3'd5
    } t_cfg_idx;

    localparam logic [7:0]  RST_BASE_HEIGHT   = 8'd0;
    localparam logic [7:0]  RST_HEIGHT_RANGE  = 8'd32;
    localparam logic [15:0] RST_FIRST_FREQ    = 16'd11796;
    localparam logic [15:0] RST_SECOND_FREQ   = 16'd24773;
    localparam logic [15:0] RST_FIRST_WEIGHT  = 16'd42598;
    localparam logic [15:0] RST_SECOND_WEIGHT = 16'd22938;

    localparam logic [8:0]  HEIGHT_MAX = 9'd510;
endpackage

// File: sv/vnh_octave.sv
// One value noise octave lane: scale, hash four corners, quintic fade, bilinear blend.
`timescale 1ns / 1ps
module vnh_octave
    import vnh_pkg::*;
(
    input  logic                      i_clk,
    input  logic [OCT_STG-1:0]        i_en,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_z,
    input  logic [FREQ_W-1:0]         i_freq,
    output logic signed [OCT_W-1:0]   o_value
);
    localparam logic [28:0] K_X  = 29'd1619;
    localparam logic [28:0] K_Z  = 29'd31337;
    localparam logic [15:0] K_MUL_LO = 16'h9F61;   // low half of 1274126177

    // low 16 bits of the mixed hash
    function automatic logic [15:0] hash_lo(input logic [28:0] h);
        logic [15:0] m;
        logic [31:0] p;
        m = h[15:0] ^ h[28:13];
        p = m * K_MUL_LO;
        return p[15:0];
    endfunction

    // corner value rhu(2v*65536/65535) - 65536
    function automatic logic signed [17:0] corner(input logic [15:0] v);
        logic [17:0] k;
        logic [17:0] s;
        k = (v >= 16'd49152) ? 18'd2 : ((v >= 16'd16384) ? 18'd1 : 18'd0);
        s = {1'b0, v, 1'b0} + k;
        return $signed(s - 18'd65536);
    endfunction

    // a + floor((t*(b-a) + 2^15) / 2^16)
    function automatic logic signed [OCT_W-1:0] lerp(input logic signed [OCT_W-1:0] a,
                                                     input logic signed [OCT_W-1:0] b,
                                                     input logic [16:0] t);
        logic signed [OCT_W:0]  d;
        logic signed [38:0]     p;
        d = $signed({b[OCT_W-1], b}) - $signed({a[OCT_W-1], a});
        p = $signed({1'b0, t}) * d + 39'sd32768;
        return a + OCT_W'(p >>> 16);
    endfunction

    // stage 1: scaled coordinates
    logic signed [32:0] r_cx, r_cz;
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cx <= i_x * $signed({1'b0, i_freq});
            r_cz <= i_z * $signed({1'b0, i_freq});
        end
    end

    // stage 2: lattice products and squared fractions
    logic [28:0] r_ha, r_hb;
    logic [15:0] r_fx, r_fz;
    logic [31:0] r_fsqx, r_fsqz;
    logic signed [45:0] n_pa, n_pb;
    always_comb begin
        n_pa = $signed(r_cx[32:16]) * $signed({1'b0, K_X});
        n_pb = $signed(r_cz[32:16]) * $signed({1'b0, K_Z});
    end
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ha   <= n_pa[28:0];
            r_hb   <= n_pb[28:0];
            r_fx   <= r_cx[15:0];
            r_fz   <= r_cz[15:0];
            r_fsqx <= r_cx[15:0] * r_cx[15:0];
            r_fsqz <= r_cz[15:0] * r_cz[15:0];
        end
    end

    // stage 3: corner hashes, f^2 and the fade polynomial tail
    logic [28:0] r_h [4];
    logic [15:0] r_f2x, r_f2z, r_f3fx, r_f3fz;
    logic [19:0] r_qx, r_qz;
    logic [28:0] n_hs;
    logic [32:0] n_f2x, n_f2z;
    logic [37:0] n_qx, n_qz;
    always_comb begin
        n_hs  = r_ha + r_hb;
        n_f2x = {1'b0, r_fsqx} + 33'd32768;
        n_f2z = {1'b0, r_fsqz} + 33'd32768;
        n_qx  = 38'(r_fsqx) * 38'd6 - 38'(r_fx) * 38'd983040 + 38'd42949705728;
        n_qz  = 38'(r_fsqz) * 38'd6 - 38'(r_fz) * 38'd983040 + 38'd42949705728;
    end
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_h[0] <= n_hs;
            r_h[1] <= n_hs + K_X;
            r_h[2] <= n_hs + K_Z;
            r_h[3] <= n_hs + K_X + K_Z;
            r_f2x  <= n_f2x[31:16];
            r_f2z  <= n_f2z[31:16];
            r_qx   <= n_qx[35:16];
            r_qz   <= n_qz[35:16];
            r_f3fx <= r_fx;
            r_f3fz <= r_fz;
        end
    end

    // stage 4: hash mixing and f^3
    logic [15:0] r_v [4];
    logic [15:0] r_f3x, r_f3z;
    logic [19:0] r_q4x, r_q4z;
    logic [32:0] n_f3x, n_f3z;
    always_comb begin
        n_f3x = 33'(r_f2x) * 33'(r_f3fx) + 33'd32768;
        n_f3z = 33'(r_f2z) * 33'(r_f3fz) + 33'd32768;
    end
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int i = 0; i < 4; i++) begin
                r_v[i] <= hash_lo(r_h[i]);
            end
            r_f3x <= n_f3x[31:16];
            r_f3z <= n_f3z[31:16];
            r_q4x <= r_qx;
            r_q4z <= r_qz;
        end
    end

    // stage 5: corner values and fade weights
    logic signed [OCT_W-1:0] r_n [4];
    logic [16:0] r_u, r_w;
    logic [36:0] n_ux, n_uz;
    always_comb begin
        n_ux = 37'(r_f3x) * 37'(r_q4x) + 37'd32768;
        n_uz = 37'(r_f3z) * 37'(r_q4z) + 37'd32768;
    end
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            for (int i = 0; i < 4; i++) begin
                r_n[i] <= OCT_W'(corner(r_v[i]));
            end
            r_u <= n_ux[32:16];
            r_w <= n_uz[32:16];
        end
    end

    // stage 6: blend along x
    logic signed [OCT_W-1:0] r_e0, r_e1;
    logic [16:0] r_w6;
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_e0 <= lerp(r_n[0], r_n[1], r_u);
            r_e1 <= lerp(r_n[2], r_n[3], r_u);
            r_w6 <= r_w;
        end
    end

    // stage 7: blend along z
    logic signed [OCT_W-1:0] r_val;
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_val <= lerp(r_e0, r_e1, r_w6);
        end
    end
    assign o_value = r_val;
endmodule

// File: sv/value_noise_heightmap_core.sv
// Top level: config registers, two octave lanes, weighting, scaling and height output.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------------------
//  request  | i_in_valid   | o_in_ready   | i_column_x, i_column_z
//  result   | o_out_valid  | i_out_ready  | o_height
//  config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// One request enters per cycle unless a held output backs up the pipe; it has 7 octave stages and 4 mixing stages.
// Throughput is set by the per-stage enable chain: a stage loads when it is empty or
// the stage after it moves, so bubbles close up while the output is held.
// Reset is synchronous, active low; it clears valid bits and loads config defaults.
// A stalled result holds in the output register; nothing is dropped or repeated.
`timescale 1ns / 1ps
module value_noise_heightmap_core
    import vnh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COORD_W-1:0] i_column_x,
    input  logic signed [COORD_W-1:0] i_column_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [HEIGHT_W-1:0]       o_height,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int NSTG = OCT_STG + 4;

    // configuration registers
    logic [7:0]  r_base, r_range;
    logic [15:0] r_freq1, r_freq2, r_wt1, r_wt2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE_HEIGHT;
            r_range <= RST_HEIGHT_RANGE;
            r_freq1 <= RST_FIRST_FREQ;
            r_freq2 <= RST_SECOND_FREQ;
            r_wt1   <= RST_FIRST_WEIGHT;
            r_wt2   <= RST_SECOND_WEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_BASE_HEIGHT:   r_base  <= i_cfg_data[7:0];
                REG_HEIGHT_RANGE:  r_range <= i_cfg_data[7:0];
                REG_FIRST_FREQ:    r_freq1 <= i_cfg_data;
                REG_SECOND_FREQ:   r_freq2 <= i_cfg_data;
                REG_FIRST_WEIGHT:  r_wt1   <= i_cfg_data;
                REG_SECOND_WEIGHT: r_wt2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables and valid bits
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   en;
    always_comb begin
        en[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end
    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // octave lanes
    logic signed [OCT_W-1:0] n1, n2;
    vnh_octave u_oct1 (
        .i_clk(i_clk), .i_en(en[OCT_STG-1:0]), .i_x(i_column_x), .i_z(i_column_z),
        .i_freq(r_freq1), .o_value(n1)
    );
    vnh_octave u_oct2 (
        .i_clk(i_clk), .i_en(en[OCT_STG-1:0]), .i_x(i_column_x), .i_z(i_column_z),
        .i_freq(r_freq2), .o_value(n2)
    );

    // weight each octave
    logic signed [36:0] r_p1, r_p2;
    always_ff @(posedge i_clk) begin
        if (en[OCT_STG]) begin
            r_p1 <= $signed({1'b0, r_wt1}) * n1;
            r_p2 <= $signed({1'b0, r_wt2}) * n2;
        end
    end

    // sum and shift up by one; the sum lies in [0, 2] only while the weights add up to at most one
    logic signed [38:0] r_m;
    always_ff @(posedge i_clk) begin
        if (en[OCT_STG+1]) begin
            r_m <= 39'(r_p1) + 39'(r_p2) + 39'sd4294967296;
        end
    end

    // scale by height range in two partial products
    logic signed [29:0] r_hi;
    logic [25:0]        r_lo;
    always_ff @(posedge i_clk) begin
        if (en[OCT_STG+2]) begin
            r_hi <= $signed(r_m[38:18]) * $signed({1'b0, r_range});
            r_lo <= r_m[17:0] * r_range;
        end
    end

    // round, add base, clamp
    logic signed [49:0] n_s;
    logic signed [16:0] n_term;
    logic signed [17:0] n_h;
    logic [HEIGHT_W-1:0] r_height;
    always_comb begin
        n_s    = (50'(r_hi) <<< 18) + $signed({24'd0, r_lo}) + 50'sd4294967296;
        n_term = 17'(n_s >>> 33);
        n_h    = 18'(n_term) + $signed({10'd0, r_base});
    end
    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            if (n_h < 0) begin
                r_height <= '0;
            end else if (n_h > $signed({9'd0, HEIGHT_MAX})) begin
                r_height <= HEIGHT_MAX;
            end else begin
                r_height <= n_h[HEIGHT_W-1:0];
            end
        end
    end
    assign o_height = r_height;

`ifndef SYNTHESIS
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_height <= HEIGHT_MAX) else $error("height out of range");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_in_ready) else $error("empty first stage not ready");
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-2] && !en[NSTG-2]) |=> r_vld[NSTG-2]) else $error("held item lost");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !r_vld[NSTG-2]) |=> !o_out_valid)
        else $error("result repeated");
`endif
endmodule

// File: sim/height_checker.sv
// Checker for the heightmap core: watches the request, result and config channels, predicts heights and compares.
`timescale 1ns / 1ps
module height_checker
    import vnh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic signed [COORD_W-1:0] i_column_x,
    input  logic signed [COORD_W-1:0] i_column_z,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [HEIGHT_W-1:0]       i_height,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_heights_seen
);
    // local copy of the config registers
    logic [7:0]  base_h;
    logic [7:0]  span_h;
    logic [15:0] freq_a;
    logic [15:0] freq_b;
    logic [15:0] wgt_a;
    logic [15:0] wgt_b;

    logic [HEIGHT_W-1:0] height_queue[$];

    // floor of v / 2^s for signed values
    function automatic longint floor_div(input longint v, input int s);
        return v >>> s;
    endfunction

    // hashed lattice corner value, signed Q1.16
    function automatic longint lattice_value(input longint cx, input longint cz);
        logic [31:0] h;
        logic [31:0] sh;
        longint      v;
        h  = 32'(cx) * 32'd1619 + 32'(cz) * 32'd31337;
        sh = $signed(h) >>> 13;
        h  = (h ^ sh) * 32'd1274126177;
        v  = longint'(h[15:0]);
        return (2 * v * 131072 + 65535) / 131070 - 65536;
    endfunction

    // quintic fade on a Q0.16 fraction
    function automatic longint quintic(input longint f);
        longint f2;
        longint f3;
        longint q;
        f2 = (f * f + 32768) >>> 16;
        f3 = (f2 * f + 32768) >>> 16;
        q  = (6 * f * f - 15 * 65536 * f + 10 * (longint'(1) << 32) + 32768) >>> 16;
        return (f3 * q + 32768) >>> 16;
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint t);
        return a + floor_div(t * (b - a) + 32768, 16);
    endfunction

    function automatic longint octave_value(input longint x, input longint z,
                                            input logic [15:0] freq);
        longint cx;
        longint cz;
        longint x0;
        longint z0;
        longint u;
        longint v;
        cx = x * longint'(freq);
        cz = z * longint'(freq);
        x0 = floor_div(cx, 16);
        z0 = floor_div(cz, 16);
        u  = quintic(cx - x0 * 65536);
        v  = quintic(cz - z0 * 65536);
        return mix(mix(lattice_value(x0, z0), lattice_value(x0 + 1, z0), u),
                   mix(lattice_value(x0, z0 + 1), lattice_value(x0 + 1, z0 + 1), u), v);
    endfunction

    function automatic logic [HEIGHT_W-1:0] column_height(input logic signed [15:0] x,
                                                          input logic signed [15:0] z);
        longint n;
        longint h;
        n = longint'(wgt_a) * octave_value(x, z, freq_a)
          + longint'(wgt_b) * octave_value(x, z, freq_b);
        h = longint'(base_h)
          + floor_div((n + (longint'(1) << 32)) * longint'(span_h) + (longint'(1) << 32), 33);
        if (h < 0) h = 0;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h[HEIGHT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_heights_seen = 0;
    end

    assign o_pending = height_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_h <= RST_BASE_HEIGHT;
            span_h <= RST_HEIGHT_RANGE;
            freq_a <= RST_FIRST_FREQ;
            freq_b <= RST_SECOND_FREQ;
            wgt_a  <= RST_FIRST_WEIGHT;
            wgt_b  <= RST_SECOND_WEIGHT;
            height_queue.delete();
        end else begin
            // config writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_HEIGHT:   base_h <= i_cfg_data[7:0];
                    REG_HEIGHT_RANGE:  span_h <= i_cfg_data[7:0];
                    REG_FIRST_FREQ:    freq_a <= i_cfg_data;
                    REG_SECOND_FREQ:   freq_b <= i_cfg_data;
                    REG_FIRST_WEIGHT:  wgt_a  <= i_cfg_data;
                    REG_SECOND_WEIGHT: wgt_b  <= i_cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (i_in_valid && i_in_ready)
                height_queue.push_back(column_height(i_column_x, i_column_z));
            // accepted result
            if (i_out_valid && i_out_ready) begin
                o_heights_seen++;
                if (height_queue.size() == 0)
                    report_mismatch($sformatf("unexpected height %0d", i_height));
                else if (height_queue[0] !== i_height)
                    report_mismatch($sformatf("height got %0d want %0d",
                                              i_height, height_queue[0]));
                if (height_queue.size() != 0)
                    void'(height_queue.pop_front());
            end
        end
    end
endmodule

// File: sim/testbench.sv
// Testbench top: drives requests, config phases and back-pressure on the heightmap core.
`timescale 1ns / 1ps
module testbench;
    import vnh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      in_valid = 0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] column_x = '0;
    logic signed [COORD_W-1:0] column_z = '0;
    logic                      out_valid;
    logic                      out_ready = 0;
    logic [HEIGHT_W-1:0]       height;
    logic                      cfg_we = 0;
    logic [CFG_IDX_W-1:0]      cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    int                        fail_count;
    int                        pending;
    int                        heights_seen;
    int                        cycle_count = 0;
    bit                        calm = 0;     // no idling on either side
    bit                        hold_off = 0; // receiver long stall
    int                        phase_count = 0;

    always #5 clk = ~clk;

    value_noise_heightmap_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_column_x(column_x), .i_column_z(column_z),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_height(height),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    height_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_column_x(column_x), .i_column_z(column_z),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_height(height),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_heights_seen(heights_seen)
    );

    // timeout
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("value_noise_heightmap_core regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off
    always @(posedge clk) begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 19);
    end

    // one request, held until accepted; valid stays up for a back-to-back follow-on
    task automatic send_column(input logic [15:0] x, input logic [15:0] z);
        if (!calm && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 19) @(posedge clk);
        end
        in_valid <= 1'b1;
        column_x <= x;
        column_z <= z;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // drop valid, then drain all heights plus pipeline latency so config is safe to change
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_all(input logic [7:0] b, input logic [7:0] r, input logic [15:0] f1,
                           input logic [15:0] f2, input logic [15:0] w1, input logic [15:0] w2);
        drain();
        write_reg(REG_BASE_HEIGHT, {8'($urandom_range(255)), b});
        write_reg(REG_HEIGHT_RANGE, {8'($urandom_range(255)), r});
        write_reg(REG_FIRST_FREQ, f1);
        write_reg(REG_SECOND_FREQ, f2);
        write_reg(REG_FIRST_WEIGHT, w1);
        write_reg(REG_SECOND_WEIGHT, w2);
        // index past the register file must be ignored
        write_reg(3'd6, 16'hffff);
        write_reg(3'd7, 16'hffff);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    task automatic random_columns(input int n);
        logic [15:0] x;
        logic [15:0] z;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: begin
                    x = 16'($urandom_range(63)) - 16'd32;
                    z = 16'($urandom_range(63)) - 16'd32;
                end
                1: begin
                    x = 16'($urandom);
                    z = 16'($urandom);
                end
                2: begin
                    x = 16'h8000 + 16'($urandom_range(3));
                    z = 16'h7fff - 16'($urandom_range(3));
                end
                default: begin
                    x = 16'($urandom_range(1023));
                    z = -16'($urandom_range(1023));
                end
            endcase
            send_column(x, z);
        end
    endtask

    initial begin
        logic [15:0] edges[6];
        edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme coordinates at reset config
        calm = 1;
        foreach (edges[i]) send_column(edges[i], edges[(i + 3) % 6]);
        send_column(16'h7fff, 16'h7fff);
        send_column(16'h8000, 16'h8000);
        // zero frequency gives a constant height
        set_all(8'd17, 8'd200, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        foreach (edges[i]) send_column(edges[i], edges[i]);
        // weights past one saturate at both ends
        set_all(8'd255, 8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        foreach (edges[i]) send_column(edges[i], edges[5 - i]);
        set_all(8'd0, 8'd255, 16'h0001, 16'hffff, 16'hffff, 16'h0000);
        foreach (edges[i]) send_column(edges[5 - i], edges[i]);

        // random: several config phases with idling
        calm = 0;
        set_all(8'd0, 8'd32, 16'd11796, 16'd24773, 16'd42598, 16'd22938);
        random_columns(250);
        calm = 1;
        random_columns(150);
        calm = 0;
        // long receiver stall with requests still offered
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge clk);
                hold_off = 0;
            end
            random_columns(40);
        join
        for (int p = 0; p < 4; p++) begin
            set_all(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
            random_columns(180);
        end
        set_all(8'd0, 8'd0, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
        random_columns(40);

        drain();
        $display("covered %0d heights over %0d config phases, incl. saturation and zero freq",
                 heights_seen, phase_count);
        if (fail_count == 0)
            $display("value_noise_heightmap_core regression: pass");
        else
            $display("value_noise_heightmap_core regression: fail");
        $finish;
    end
endmodule

// File: files.f
sv/vnh_pkg.sv
sv/vnh_octave.sv
sv/value_noise_heightmap_core.sv
sim/height_checker.sv
sim/testbench.sv
